// File: sv/sliding_window_range_peak_core_assert.svh
// assertion macros used by the checker file
`ifndef SLIDING_WINDOW_RANGE_PEAK_CORE_ASSERT_SVH
`define SLIDING_WINDOW_RANGE_PEAK_CORE_ASSERT_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define SWRP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent holds in this cycle, consequent in the next cycle
`define SWRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: sv/swrp_pkg.sv
// shared types and constants of the sliding window range peak block
`timescale 1ns / 1ps

package swrp_pkg;

   localparam int SAMPLE_W = 32;
   localparam int CSR_W    = 7;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [SAMPLE_W-1:0]        spread_type;
   typedef logic [CSR_W-1:0]           csr_type;

   // commands from the sequencer to the cell row
   typedef struct packed {
      logic shift;    // push a new sample in at cell 0
      logic rotate;   // rotate the ring one place toward cell 0
   } chain_ctrl_type;

endpackage

// File: sv/swrp_req_if.sv
// sample input channel
`timescale 1ns / 1ps

interface swrp_req_if;
   logic                valid;
   logic                ready;
   swrp_pkg::sample_type sample;
   logic                last;

   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

// File: sv/swrp_rsp_if.sv
// result output channel
`timescale 1ns / 1ps

interface swrp_rsp_if;
   logic                valid;
   logic                ready;
   swrp_pkg::spread_type largest_spread;

   modport source (output valid, output largest_spread, input ready);
   modport sink (input valid, input largest_spread, output ready);
endinterface

// File: sv/swrp_cell.sv
// one window cell: holds a sample, takes it from either neighbor
`timescale 1ns / 1ps

module swrp_cell (
   input  logic                       clock,
   input  swrp_pkg::chain_ctrl_type   ctrl,
   input  swrp_pkg::sample_type       shift_data,
   input  swrp_pkg::sample_type       rot_data,
   output swrp_pkg::sample_type       value
);

   swrp_pkg::sample_type value_ff;
   swrp_pkg::sample_type value_in;

   // shift brings the newer neighbor's value (cell i-1), rotate the older one's (cell i+1)
   always_comb begin
      value_in = value_ff;
      if (ctrl.shift) begin
         value_in = shift_data;
      end else if (ctrl.rotate) begin
         value_in = rot_data;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// File: sv/swrp_chain.sv
// ring of window cells, newest sample at cell 0
`timescale 1ns / 1ps

module swrp_chain #(
   parameter int NUM_CELLS = 64
) (
   input  logic                       clock,
   input  swrp_pkg::chain_ctrl_type   ctrl,
   input  swrp_pkg::sample_type       sample,
   output swrp_pkg::sample_type       head
);

   swrp_pkg::sample_type cell_val [NUM_CELLS];

   // cell i shifts from i-1 and rotates from i+1 (wrapping)
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      swrp_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .shift_data ((i == 0) ? sample : cell_val[(i + NUM_CELLS - 1) % NUM_CELLS]),
         .rot_data   (cell_val[(i + 1) % NUM_CELLS]),
         .value      (cell_val[i])
      );
   end

   assign head = cell_val[0];

endmodule

// File: sv/sliding_window_range_peak_core.sv
// top level of the sliding window range peak block
// Usage:
//  req_chan carries one signed 32-bit sample and a last flag per transfer.
//  After each sample the block takes max minus min over the newest
//  window_size samples of the sequence (fewer at its start) and keeps the
//  largest such spread. On the last sample that spread leaves on rsp_chan
//  as one transfer and the sequence state clears.
//  csr_write_enable/csr_write_data set window_size (0 acts as 1, values
//  above WINDOW_MAX act as WINDOW_MAX); write only while idle.
// Steps:
//  each sample occupies the block through accept, a full turn of the cell
//  ring past its head comparator, subtract and compare; the compare step
//  of a last sample loads the result register. req_chan.ready is high
//  only when idle, so a sample is taken only once the sample before it is done.
// Stall: the result waits in an output register, and the next sample is
//  still taken; a later last sample waits in its final step until that
//  result has gone.
// Reset: synchronous, clears the fill count, best spread, result valid and
//  sets window_size to 1.
`timescale 1ns / 1ps

module sliding_window_range_peak_core #(
   parameter int WINDOW_MAX = 64
) (
   input  logic                clock,
   input  logic                reset,
   swrp_req_if.sink            req_chan,
   swrp_rsp_if.source          rsp_chan,
   input  logic                csr_write_enable,
   input  swrp_pkg::csr_type   csr_write_data
);

   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int WW = (CW > swrp_pkg::CSR_W) ? CW : swrp_pkg::CSR_W;
   localparam logic [CW-1:0] LAST_K  = CW'(WINDOW_MAX - 1);
   localparam logic [CW-1:0] FULL_CT = CW'(WINDOW_MAX);
   localparam logic [WW-1:0] MAX_W   = WW'(WINDOW_MAX);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DIFF = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]            state_ff, state_in;
   swrp_pkg::csr_type     win_size_ff, win_size_in;
   logic [CW-1:0]         filled_ff, filled_in;
   logic [CW-1:0]         k_ff, k_in;
   logic                  last_ff, last_in;
   swrp_pkg::sample_type  hi_ff, hi_in, lo_ff, lo_in;
   swrp_pkg::spread_type  spread_ff, spread_in;
   swrp_pkg::spread_type  best_ff, best_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   swrp_pkg::spread_type  rsp_data_ff, rsp_data_in;

   swrp_pkg::chain_ctrl_type ctrl;
   swrp_pkg::sample_type     head;
   logic                     req_fire;
   logic [WW-1:0]            ws_ext, ws_lim;
   logic [CW-1:0]            eff_w;
   swrp_pkg::spread_type     best_new;

   swrp_chain #(
      .NUM_CELLS (WINDOW_MAX)
   ) u_chain (
      .clock  (clock),
      .ctrl   (ctrl),
      .sample (req_chan.sample),
      .head   (head)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // effective window: size 0 as 1, clamp to ring length, then to fill count
   always_comb begin
      ws_ext = WW'(win_size_ff);
      if (ws_ext == '0) begin
         ws_ext = WW'(1);
      end
      ws_lim = (ws_ext > MAX_W) ? MAX_W : ws_ext;
      eff_w  = (ws_lim > WW'(filled_ff)) ? filled_ff : ws_lim[CW-1:0];
   end

   assign best_new = (spread_ff > best_ff) ? spread_ff : best_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      win_size_in  = win_size_ff;
      filled_in    = filled_ff;
      k_in         = k_ff;
      last_in      = last_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      spread_in    = spread_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ctrl.shift   = 1'b0;
      ctrl.rotate  = 1'b0;

      if (csr_write_enable) begin
         win_size_in = csr_write_data;
      end
      // result transfer frees the output register
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ctrl.shift = 1'b1;
               last_in    = req_chan.last;
               hi_in      = req_chan.sample;
               lo_in      = req_chan.sample;
               k_in       = '0;
               if (filled_ff != FULL_CT) begin
                  filled_in = filled_ff + CW'(1);
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // head shows the k-th newest sample
            ctrl.rotate = 1'b1;
            if (k_ff < eff_w) begin
               if (head > hi_ff) begin
                  hi_in = head;
               end
               if (head < lo_ff) begin
                  lo_in = head;
               end
            end
            k_in = k_ff + CW'(1);
            if (k_ff == LAST_K) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            spread_in = swrp_pkg::spread_type'(hi_ff) - swrp_pkg::spread_type'(lo_ff);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!last_ff) begin
               best_in  = best_new;
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = best_new;
               best_in      = '0;
               filled_in    = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_size_ff  <= swrp_pkg::csr_type'(1);
         filled_ff    <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_size_ff  <= win_size_in;
         filled_ff    <= filled_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      last_ff     <= last_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      spread_ff   <= spread_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.largest_spread = rsp_data_ff;

endmodule

// File: sv/swrp_checker.sv
// port-level checks for the sliding window range peak block
`timescale 1ns / 1ps
`include "sliding_window_range_peak_core_assert.svh"

module swrp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_last,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input swrp_pkg::spread_type rsp_spread
);

   // a pending result stays offered
   `SWRP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // a stalled result keeps its value
   `SWRP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_spread))
   // a sample transfer starts the scan, so the next one cannot follow at once
   `SWRP_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && req_ready, !req_ready)
   // a sample that is not last never raises a result
   `SWRP_ASSERT_NEXT(a_no_spurious, clock, reset,
      req_valid && req_ready && !req_last && !rsp_valid, !rsp_valid)

endmodule

bind sliding_window_range_peak_core swrp_checker u_swrp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_last   (req_chan.last),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_spread (rsp_chan.largest_spread)
);

// File: test/tb_sliding_window_range_peak_core.sv
// testbench for the sliding window range peak core: random and directed samples, scoreboarded
`timescale 1ns / 1ps

module tb_sliding_window_range_peak_core;

   localparam int WINDOW_MAX  = 64;
   localparam int ITEM_CYCLES = WINDOW_MAX + 3;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int ITEM_TARGET = 1050;
   localparam swrp_pkg::sample_type SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam swrp_pkg::sample_type SAMPLE_MIN = 32'sh8000_0000;

   typedef struct {
      swrp_pkg::sample_type sample;
      logic                 last;
   } sample_xfer_type;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   swrp_pkg::csr_type csr_write_data;

   swrp_req_if req_if ();
   swrp_rsp_if rsp_if ();

   sliding_window_range_peak_core #(
      .WINDOW_MAX(WINDOW_MAX)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // samples waiting to be sent and spreads waiting to come back
   sample_xfer_type      pending_samples[$];
   swrp_pkg::spread_type expected_spreads[$];

   // shadow of the block's sequence state
   swrp_pkg::sample_type recent_samples[WINDOW_MAX];
   int unsigned          held_count;
   int unsigned          next_slot;
   swrp_pkg::spread_type peak_spread;
   swrp_pkg::csr_type    window_reg;

   int unsigned samples_in_flight = 0;
   int unsigned samples_sent      = 0;
   int unsigned sequences_sent    = 0;
   int unsigned settings_written  = 0;
   int unsigned spreads_checked   = 0;
   int unsigned mismatch_count    = 0;
   int unsigned cycle_count       = 0;
   int unsigned idle_pct          = 0;
   int unsigned src_gap;
   int unsigned sink_stall;

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // log a failure, only the first few in detail
   function automatic void note_mismatch(input string what, input swrp_pkg::spread_type want,
                                         input swrp_pkg::spread_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %0d: %s expected %h got %h", mismatch_count, what, want, got);
   endfunction

   // push one sample into the window shadow, update the running peak, queue it on the last sample
   function automatic void track_sample(input swrp_pkg::sample_type s, input logic is_last);
      int unsigned          span;
      int unsigned          idx;
      int unsigned          k;
      swrp_pkg::sample_type hi;
      swrp_pkg::sample_type lo;
      swrp_pkg::spread_type spread;
      recent_samples[next_slot] = s;
      next_slot = (next_slot + 1) % WINDOW_MAX;
      if (held_count < WINDOW_MAX)
         held_count++;
      span = int'(window_reg);
      if (span == 0)
         span = 1;
      if (span > WINDOW_MAX)
         span = WINDOW_MAX;
      if (span > held_count)
         span = held_count;
      // walk back over the newest span samples
      hi  = s;
      lo  = s;
      idx = next_slot;
      for (k = 0; k < span; k++) begin
         idx = (idx + WINDOW_MAX - 1) % WINDOW_MAX;
         if (recent_samples[idx] > hi)
            hi = recent_samples[idx];
         if (recent_samples[idx] < lo)
            lo = recent_samples[idx];
      end
      spread = swrp_pkg::spread_type'(hi) - swrp_pkg::spread_type'(lo);
      if (spread > peak_spread)
         peak_spread = spread;
      // end of sequence: emit peak and clear
      if (is_last) begin
         expected_spreads.push_back(peak_spread);
         held_count  = 0;
         next_slot   = 0;
         peak_spread = '0;
      end
   endfunction

   // sample source
   always @(posedge clock) begin : drive_samples
      sample_xfer_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
         src_gap = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (src_gap != 0) begin
            src_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_samples.size() != 0) begin
            nxt = pending_samples.pop_front();
            req_if.valid  <= 1'b1;
            req_if.sample <= nxt.sample;
            req_if.last   <= nxt.last;
            // idle burst after this transfer
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
               src_gap = $urandom_range(1, 14);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result sink with random stall bursts
   always @(posedge clock) begin : drain_results
      if (reset) begin
         rsp_if.ready <= 1'b0;
         sink_stall = 0;
      end else if (sink_stall != 0) begin
         sink_stall--;
         rsp_if.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
         sink_stall = $urandom_range(0, 13);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // monitor: register writes, result checks, sample prediction
   always @(posedge clock) begin : watch_ports
      swrp_pkg::spread_type want;
      if (reset) begin
         held_count  = 0;
         next_slot   = 0;
         peak_spread = '0;
         window_reg  = swrp_pkg::csr_type'(1);
      end else begin
         if (csr_write_enable)
            window_reg = csr_write_data;
         if (rsp_if.valid && rsp_if.ready) begin
            spreads_checked++;
            if (expected_spreads.size() == 0) begin
               note_mismatch("unexpected transfer, largest_spread", '0, rsp_if.largest_spread);
            end else begin
               want = expected_spreads.pop_front();
               if (rsp_if.largest_spread !== want)
                  note_mismatch("largest_spread", want, rsp_if.largest_spread);
            end
         end
         if (req_if.valid && req_if.ready) begin
            track_sample(req_if.sample, req_if.last);
            samples_in_flight--;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic add_sample(input swrp_pkg::sample_type s, input logic is_last);
      sample_xfer_type x;
      x.sample = s;
      x.last   = is_last;
      pending_samples.push_back(x);
      samples_in_flight++;
      samples_sent++;
      if (is_last)
         sequences_sent++;
   endtask

   // wait until all samples are taken and all spreads are back, then let the block finish
   task automatic wait_quiet();
      while (samples_in_flight != 0 || expected_spreads.size() != 0)
         @(posedge clock);
      repeat (ITEM_CYCLES + 8) @(posedge clock);
   endtask

   task automatic write_window(input swrp_pkg::csr_type value);
      wait_quiet();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_written++;
   endtask

   function automatic swrp_pkg::sample_type pick_sample(input int unsigned style);
      case (style)
         0: return swrp_pkg::sample_type'($urandom);
         1: return swrp_pkg::sample_type'(int'($urandom_range(0, 200)) - 100);
         2: return SAMPLE_MAX - swrp_pkg::sample_type'($urandom_range(0, 50));
         3: return SAMPLE_MIN + swrp_pkg::sample_type'($urandom_range(0, 50));
         default: begin
            case ($urandom_range(0, 4))
               0: return SAMPLE_MAX;
               1: return SAMPLE_MIN;
               2: return '0;
               3: return -1;
               default: return swrp_pkg::sample_type'($urandom);
            endcase
         end
      endcase
   endfunction

   function automatic swrp_pkg::csr_type pick_window();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0: return 7'd0;
               1: return 7'd1;
               2: return 7'(WINDOW_MAX);
               default: return 7'd127;
            endcase
         end
         1: return swrp_pkg::csr_type'($urandom_range(WINDOW_MAX + 1, 127));
         default: return swrp_pkg::csr_type'($urandom_range(1, WINDOW_MAX));
      endcase
   endfunction

   // random sequences; an open end leaves the last sequence running into the next phase
   task automatic random_phase(input int unsigned count, input bit open_end);
      int unsigned remaining;
      int unsigned len;
      int unsigned style;
      int unsigned k;
      remaining = count;
      while (remaining > 0) begin
         case ($urandom_range(0, 9))
            0:       len = $urandom_range(65, 150);
            1, 2:    len = $urandom_range(13, 64);
            default: len = $urandom_range(1, 12);
         endcase
         if (len > remaining)
            len = remaining;
         style = $urandom_range(0, 4);
         for (k = 0; k < len; k++)
            add_sample(pick_sample(style),
                       (k == len - 1) && !(open_end && remaining == len));
         remaining -= len;
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.sample    = '0;
      req_if.last      = 1'b0;
      rsp_if.ready     = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset window of one: every spread is zero, single-sample sequence too
      add_sample(SAMPLE_MAX, 1'b0);
      add_sample(SAMPLE_MIN, 1'b1);
      add_sample(32'sd5, 1'b1);
      // full window: largest possible spread
      write_window(7'(WINDOW_MAX));
      add_sample(SAMPLE_MAX, 1'b0);
      add_sample(SAMPLE_MIN, 1'b1);
      add_sample(SAMPLE_MIN, 1'b0);
      add_sample(-32'sd1, 1'b0);
      add_sample(SAMPLE_MAX, 1'b1);
      // zero size acts as one
      write_window(7'd0);
      add_sample(32'sd3, 1'b0);
      add_sample(-32'sd7, 1'b1);
      // size above the store depth saturates
      write_window(7'd127);
      add_sample(SAMPLE_MIN, 1'b0);
      add_sample(32'sd0, 1'b0);
      add_sample(SAMPLE_MAX, 1'b1);
      // size change in the middle of a sequence
      write_window(7'd2);
      add_sample(32'sd10, 1'b0);
      add_sample(-32'sd10, 1'b0);
      add_sample(32'sd40, 1'b0);
      write_window(7'd3);
      add_sample(32'sd0, 1'b0);
      add_sample(-32'sd50, 1'b1);
      write_window(7'(WINDOW_MAX + 1));
      add_sample(32'sd1, 1'b0);
      add_sample(32'sd2, 1'b1);

      // random phases, each under its own window and idle rate
      while (samples_sent < ITEM_TARGET - 120) begin
         write_window(pick_window());
         case ($urandom_range(0, 3))
            0:       idle_pct = 0;
            1:       idle_pct = 15;
            default: idle_pct = 40;
         endcase
         random_phase($urandom_range(60, 120), $urandom_range(0, 3) == 0);
      end

      // closing stretch at full rate
      write_window(pick_window());
      idle_pct = 0;
      random_phase(120, 1'b0);
      wait_quiet();
      if (expected_spreads.size() != 0)
         note_mismatch("missing transfer, largest_spread", expected_spreads[0], '0);

      $display("sent %0d samples in %0d sequences under %0d window settings",
               samples_sent, sequences_sent, settings_written);
      $display("checked %0d spreads in %0d cycles, %0d mismatches",
               spreads_checked, cycle_count, mismatch_count);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
